@@ src/mewma_pkg.sv @@
package mewma_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W       = 8;
    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 16;
    localparam int MODE_W     = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_FAST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_FAST_GAIN = 1'b0;
    localparam logic REG_SLOW_GAIN = 1'b1;

    localparam logic [GAIN_W-1:0] FAST_GAIN_RST = 16'd6554;
    localparam logic [GAIN_W-1:0] SLOW_GAIN_RST = 16'd2182;

    typedef struct packed {
        logic [GAIN_W-1:0] fast;
        logic [GAIN_W-1:0] slow;
    } mewma_gains_t;

    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
        logic [SAMPLE_W-1:0] data;
    } mewma_wr_t;

endpackage

@@ src/mewma_cfg.sv @@
module mewma_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mewma_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mewma_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mewma_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output mewma_pkg::mewma_gains_t         gains
);
    import mewma_pkg::*;

    mewma_gains_t gains_reg;
    mewma_gains_t gains_next;
    logic         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_FAST_GAIN: gains_next.fast = pwdata[GAIN_W-1:0];
                REG_SLOW_GAIN: gains_next.slow = pwdata[GAIN_W-1:0];
                default:       gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.fast <= FAST_GAIN_RST;
            gains_reg.slow <= SLOW_GAIN_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FAST_GAIN: prdata = APB_DATA_W'(gains_reg.fast);
            REG_SLOW_GAIN: prdata = APB_DATA_W'(gains_reg.slow);
            default:       prdata = '0;
        endcase
    end

    assign gains = gains_reg;

endmodule

@@ src/mewma_store.sv @@
module mewma_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mewma_pkg::CH_IDX_W-1:0]      rd_idx,
    output logic signed [mewma_pkg::SAMPLE_W-1:0] rd_data,
    input  mewma_pkg::mewma_wr_t                wr
);
    import mewma_pkg::*;

    logic [SAMPLE_W-1:0] smoothed_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                smoothed_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            smoothed_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = $signed(smoothed_reg[rd_idx]);

endmodule

@@ src/mewma_update.sv @@
module mewma_update (
    input  logic signed [mewma_pkg::SAMPLE_W-1:0] sample,
    input  logic [mewma_pkg::CH_W-1:0]            channel,
    input  logic [mewma_pkg::MODE_W-1:0]          mode,
    input  logic signed [mewma_pkg::SAMPLE_W-1:0] smoothed,
    input  mewma_pkg::mewma_gains_t               gains,
    output logic signed [mewma_pkg::SAMPLE_W-1:0] result,
    output mewma_pkg::mewma_wr_t                  wr
);
    import mewma_pkg::*;

    logic                          in_range;
    logic [GAIN_W-1:0]             gain;
    logic signed [SAMPLE_W:0]      diff;
    logic signed [GAIN_W:0]        gain_s;
    logic signed [SAMPLE_W+GAIN_W+1:0] prod;
    logic [SAMPLE_W-1:0]           upd;

    always_comb
    begin
        in_range = {1'b0, channel} < (CH_W+1)'(CHANNELS);
        // unused mode code behaves as slow
        gain     = (mode == MODE_FAST) ? gains.fast : gains.slow;
        gain_s   = $signed({1'b0, gain});
        diff     = {sample[SAMPLE_W-1], sample} - {smoothed[SAMPLE_W-1], smoothed};
        prod     = diff * gain_s;
        // arithmetic shift by 16 is a floor; only the low word of the sum matters
        upd      = smoothed + prod[SAMPLE_W+GAIN_W-1:GAIN_W];

        result   = sample;
        wr.en    = in_range;
        wr.idx   = channel[CH_IDX_W-1:0];
        wr.data  = '0;
        if (in_range && (mode != MODE_CLEAR))
        begin
            result  = $signed(upd);
            wr.data = upd;
        end
    end

endmodule

@@ src/multichannel_ewma_filter_top.sv @@
// Multichannel EWMA filter. Each request carries a Q16.16 sample, a channel and a
// mode; the block returns one filtered value per request, s + floor((x - s) * gain
// / 2^16) for fast or slow mode, or the sample itself on clear or on a channel at
// or above CHANNELS. One request is taken every clock cycle unless the output stalls;
// a result passes the input register, then the result register, with a single subtract,
// a 33 x 17 multiply and an add between them. The per-channel store is read and written
// in the input-register stage, so consecutive requests to one channel run at full rate.
// Reset clears the store at once; no clearing pass is needed. Gains are written over APB
// at 0x0 (fast) and 0x4 (slow) only while the block is idle: a user rule, not enforced.
module multichannel_ewma_filter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mewma_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mewma_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mewma_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [mewma_pkg::SAMPLE_W-1:0] sample,
    input  logic [mewma_pkg::CH_W-1:0]            channel,
    input  logic [mewma_pkg::MODE_W-1:0]          mode,
    output logic                                  filtered_valid,
    input  logic                                  filtered_ready,
    output logic signed [mewma_pkg::SAMPLE_W-1:0] filtered
);
    import mewma_pkg::*;

    mewma_gains_t               gains;
    mewma_wr_t                  upd_wr;
    mewma_wr_t                  store_wr;
    logic signed [SAMPLE_W-1:0] smoothed;
    logic signed [SAMPLE_W-1:0] result;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [CH_W-1:0]            s1_channel_reg;
    logic [MODE_W-1:0]          s1_mode_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic                       out_free;
    logic                       s1_adv;
    logic                       in_take;

    assign out_free     = !out_valid_reg || filtered_ready;
    assign s1_adv       = s1_valid_reg && out_free;
    assign sample_ready = !s1_valid_reg || out_free;
    assign in_take      = sample_valid && sample_ready;

    mewma_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    mewma_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (s1_channel_reg[CH_IDX_W-1:0]),
        .rd_data (smoothed),
        .wr      (store_wr)
    );

    mewma_update u_update (
        .sample   (s1_sample_reg),
        .channel  (s1_channel_reg),
        .mode     (s1_mode_reg),
        .smoothed (smoothed),
        .gains    (gains),
        .result   (result),
        .wr       (upd_wr)
    );

    always_comb
    begin
        store_wr    = upd_wr;
        store_wr.en = upd_wr.en && s1_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg  <= sample;
            s1_channel_reg <= channel;
            s1_mode_reg    <= mode;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    assign filtered_valid = out_valid_reg;
    assign filtered       = out_data_reg;

endmodule

@@ src/mewma_checker.sv @@
module mewma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        sample_ready,
    input logic        filtered_valid,
    input logic        filtered_ready,
    input logic [31:0] filtered
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        filtered_valid && !filtered_ready |=> filtered_valid && $stable(filtered))
        else $error("stalled result changed");

    // with the result register empty the input side can never be blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !filtered_valid |-> sample_ready)
        else $error("input blocked while output empty");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // gain written then read back in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == 1'b0))
        ##1 (psel && !pwrite && (paddr[2] == 1'b0))
        |-> prdata == {16'b0, $past(pwdata[15:0])})
        else $error("fast gain readback mismatch");

endmodule

bind multichannel_ewma_filter_top mewma_checker u_mewma_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_ready   (sample_ready),
    .filtered_valid (filtered_valid),
    .filtered_ready (filtered_ready),
    .filtered       (filtered)
);

@@ verif/tb_multichannel_ewma_filter_top.sv @@
module tb_multichannel_ewma_filter_top;

    import mewma_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;  // unused code, behaves as slow
    localparam int                RAND_PHASES  = 8;
    localparam int                PHASE_ITEMS  = 230;
    localparam int                STALL_LIMIT  = 4000;
    localparam int                DRAIN_CYCLES = 6;
    localparam int                MAX_REPORTS  = 40;

    typedef enum logic [1:0] {STEP_REQ, STEP_SET_FAST, STEP_SET_SLOW} step_kind_t;

    typedef struct {
        step_kind_t          kind;
        logic [SAMPLE_W-1:0] value;   // sample, or gain for a register step
        logic [CH_W-1:0]     ch;
        logic [MODE_W-1:0]   md;
        bit                  pinned;
        logic [SAMPLE_W-1:0] want;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{STEP_REQ, 32'h0001_0000, 8'd0,   MODE_FAST,  1'b1, 32'd6554},
        '{STEP_REQ, 32'h8000_0000, 8'd9,   MODE_FAST,  1'b1, 32'h8000_0000},
        '{STEP_REQ, 32'h7FFF_FFFF, 8'd255, MODE_SLOW,  1'b1, 32'h7FFF_FFFF},
        '{STEP_REQ, 32'h0000_0005, 8'd8,   MODE_CLEAR, 1'b1, 32'h0000_0005},
        '{STEP_REQ, 32'h1234_5678, 8'd1,   MODE_CLEAR, 1'b1, 32'h1234_5678},
        '{STEP_REQ, 32'h7FFF_FFFF, 8'd2,   MODE_FAST,  1'b0, 32'h0},
        '{STEP_REQ, 32'h8000_0000, 8'd2,   MODE_SLOW,  1'b0, 32'h0},
        '{STEP_REQ, 32'h8000_0000, 8'd2,   MODE_FAST,  1'b0, 32'h0},
        '{STEP_REQ, 32'hFFFF_FFFF, 8'd3,   MODE_SPARE, 1'b1, 32'hFFFF_FFFF},
        '{STEP_REQ, 32'h7FFF_FFFF, 8'd3,   MODE_SPARE, 1'b0, 32'h0},
        '{STEP_REQ, 32'h7FFF_FFFF, 8'd7,   MODE_FAST,  1'b0, 32'h0},
        '{STEP_REQ, 32'h8000_0000, 8'd7,   MODE_FAST,  1'b0, 32'h0},
        '{STEP_REQ, 32'h0000_0000, 8'd2,   MODE_CLEAR, 1'b1, 32'h0000_0000},
        '{STEP_REQ, 32'h0000_0000, 8'd2,   MODE_FAST,  1'b1, 32'h0000_0000},
        '{STEP_SET_FAST, 32'd0,    8'd0,   MODE_FAST,  1'b0, 32'h0},
        '{STEP_REQ, 32'h7FFF_FFFF, 8'd0,   MODE_FAST,  1'b1, 32'd6554},
        '{STEP_REQ, 32'h8000_0000, 8'd0,   MODE_FAST,  1'b1, 32'd6554},
        '{STEP_SET_SLOW, 32'd65535, 8'd0,  MODE_FAST,  1'b0, 32'h0},
        '{STEP_REQ, 32'h0001_0000, 8'd5,   MODE_SLOW,  1'b1, 32'd65535},
        '{STEP_REQ, 32'h7FFF_FFFF, 8'd6,   MODE_SLOW,  1'b0, 32'h0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  sample_valid;
    logic                  sample_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]       channel;
    logic [MODE_W-1:0]     mode;
    logic                  filtered_valid;
    logic                  filtered_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered;

    // pinned result travels with the request it belongs to
    logic                  pin_en;
    logic [SAMPLE_W-1:0]   pin_value;

    logic signed [SAMPLE_W-1:0] ewma_state [CHANNELS];
    logic [GAIN_W-1:0]     fast_gain_m;
    logic [GAIN_W-1:0]     slow_gain_m;
    logic [SAMPLE_W-1:0]   filtered_due [$];

    int unsigned           fail_count;
    int unsigned           quiet_cycles = 0;
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;

    multichannel_ewma_filter_top dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [SAMPLE_W-1:0] ewma_update(
        input logic signed [SAMPLE_W-1:0] x,
        input logic [CH_W-1:0]            ch,
        input logic [MODE_W-1:0]          md
    );
        logic [GAIN_W-1:0] g;
        longint            s;
        longint            diff;
        longint            scaled;
        if (ch >= CHANNELS)
            return x;
        if (md == MODE_CLEAR)
        begin
            ewma_state[ch[CH_IDX_W-1:0]] = '0;
            return x;
        end
        g      = (md == MODE_FAST) ? fast_gain_m : slow_gain_m;
        s      = ewma_state[ch[CH_IDX_W-1:0]];
        diff   = longint'(x) - s;
        scaled = (diff * longint'(g)) >>> 16;   // floor, not truncation
        ewma_state[ch[CH_IDX_W-1:0]] = SAMPLE_W'(s + scaled);
        return ewma_state[ch[CH_IDX_W-1:0]];
    endfunction

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endtask

    // request acceptance, result checking and the stall watchdog share one edge
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] due;
        logic [SAMPLE_W-1:0] pred;
        if (rst_n)
        begin
            if (filtered_valid && filtered_ready)
            begin
                if (filtered_due.size() == 0)
                    report($sformatf("result %h with no request outstanding", filtered));
                else
                begin
                    due = filtered_due.pop_front();
                    if (filtered !== due)
                        report($sformatf("filtered %h, want %h", filtered, due));
                end
            end
            if (sample_valid && sample_ready)
            begin
                pred = ewma_update(sample, channel, mode);
                filtered_due.push_back(pin_en ? pin_value : pred);
            end
        end
        if ((sample_valid && sample_ready) || (filtered_valid && filtered_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("multichannel_ewma_filter_top: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
        filtered_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_request(
        input logic [SAMPLE_W-1:0] x,
        input logic [CH_W-1:0]     ch,
        input logic [MODE_W-1:0]   md,
        input bit                  pinned,
        input logic [SAMPLE_W-1:0] want
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= x;
        channel      <= ch;
        mode         <= md;
        pin_en       <= pinned;
        pin_value    <= want;
        do
            @(posedge clk);
        while (!sample_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [GAIN_W-1:0] gain);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DATA_W'(gain);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_idx == REG_FAST_GAIN)
            fast_gain_m = gain;
        else
            slow_gain_m = gain;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic reg_idx, input logic [GAIN_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(want))
            report($sformatf("gain register %0d reads %h, want %h", reg_idx, prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [GAIN_W-1:0]   g_fast;
        logic [GAIN_W-1:0]   g_slow;
        logic [SAMPLE_W-1:0] x;
        logic [CH_W-1:0]     ch;
        logic [CH_W-1:0]     hot_ch;
        logic [MODE_W-1:0]   md;
        int unsigned         r;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sample_valid   = 1'b0;
        sample         = '0;
        channel        = '0;
        mode           = MODE_FAST;
        pin_en         = 1'b0;
        pin_value      = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fast_gain_m    = FAST_GAIN_RST;
        slow_gain_m    = SLOW_GAIN_RST;
        hot_ch         = '0;
        foreach (ewma_state[i])
            ewma_state[i] = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_check(REG_FAST_GAIN, FAST_GAIN_RST);
        apb_check(REG_SLOW_GAIN, SLOW_GAIN_RST);

        foreach (dir_table[i])
        begin
            case (dir_table[i].kind)
                STEP_SET_FAST:
                begin
                    wait_drained();
                    apb_write(REG_FAST_GAIN, GAIN_W'(dir_table[i].value));
                end
                STEP_SET_SLOW:
                begin
                    wait_drained();
                    apb_write(REG_SLOW_GAIN, GAIN_W'(dir_table[i].value));
                end
                default:
                    send_request(dir_table[i].value, dir_table[i].ch, dir_table[i].md,
                                 dir_table[i].pinned, dir_table[i].want);
            endcase
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       begin g_fast = 16'd0;         g_slow = 16'd65535;       end
                1:       begin g_fast = 16'd65535;     g_slow = 16'd0;           end
                3:       begin g_fast = 16'd1;         g_slow = 16'd32768;       end
                5:       begin g_fast = FAST_GAIN_RST; g_slow = SLOW_GAIN_RST;   end
                6:       begin g_fast = 16'd65535;     g_slow = 16'd65535;       end
                default: begin g_fast = GAIN_W'($urandom); g_slow = GAIN_W'($urandom); end
            endcase
            apb_write(REG_FAST_GAIN, g_fast);
            apb_write(REG_SLOW_GAIN, g_slow);
            apb_check(REG_FAST_GAIN, g_fast);
            apb_check(REG_SLOW_GAIN, g_slow);

            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // bursts on one channel exercise back-to-back updates of one store entry
                if ($urandom_range(15) == 0)
                    hot_ch = CH_W'($urandom_range(CHANNELS - 1));
                r = $urandom_range(99);
                if (r < 15)
                    ch = CH_W'($urandom_range(255, CHANNELS));
                else if (r < 50)
                    ch = hot_ch;
                else
                    ch = CH_W'($urandom_range(CHANNELS - 1));

                r = $urandom_range(99);
                if (r < 6)
                    md = MODE_CLEAR;
                else if (r < 16)
                    md = MODE_SPARE;
                else
                    md = $urandom_range(1) ? MODE_SLOW : MODE_FAST;

                case ($urandom_range(9))
                    0:       x = 32'h7FFF_FFFF;
                    1:       x = 32'h8000_0000;
                    2, 3:    x = SAMPLE_W'($urandom_range(131072)) - 32'h0001_0000;
                    default: x = $urandom;
                endcase

                send_request(x, ch, md, 1'b0, '0);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("multichannel_ewma_filter_top: match");
        else
            $display("multichannel_ewma_filter_top: mismatch");
        $finish;
    end

endmodule
